>>> rtl/fatce_pkg.sv
package fatce_pkg;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_RD_WAIT,
    FSM_SCAN,
    FSM_WALK_CHECK,
    FSM_WALK_DATA
  } fsm_state_t;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_ALLOC = 2'd2,
    MODE_FREE  = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_LOOP    = 2'd3;

  localparam logic [15:0] ENTRY_FREE      = 16'h0000;
  localparam logic [15:0] ENTRY_EOC       = 16'hFFFF;
  localparam logic [15:0] CHAIN_END_FLOOR = 16'hFFF8;
  localparam logic [16:0] RESERVED_FLOOR  = 17'h0FFF0;
  localparam logic [15:0] MIN_LINK        = 16'd2;

  localparam int          LIMIT_W     = 13;
  localparam logic [12:0] LIMIT_RESET = 13'd4096;

endpackage

>>> rtl/fatce_ram.sv
module fatce_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fat16_cluster_chain_engine.sv
// FAT16 allocation table engine, one result transaction per request; done is a
// one-cycle strobe and the receiver cannot stall it. A write completes on acceptance, a
// read waits for the table read (a read past the table completes on acceptance), allocate
// scans upward from cluster 2 for a free entry, and free walks the chain, freeing each entry.
// One request at a time: busy drops as done rises, and no request is accepted while busy.
// Synchronous rst starts a clearing pass that writes every entry free, with busy high.
module fat16_cluster_chain_engine #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // request transaction: accepted when start && !busy
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [15:0] cluster,
  input  logic [15:0] value,
  // result transaction: one cycle strobe, no backpressure
  output logic        done,
  output logic [15:0] result_value,
  output logic [1:0]  status,
  // cluster_limit register write
  input  logic        cfg_write,
  input  logic [12:0] cfg_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // usable limit never exceeds the table size or the reserved range
  localparam logic [16:0] CAP = (TABLE_ENTRIES < 65520) ? 17'(TABLE_ENTRIES)
                                                         : fatce_pkg::RESERVED_FLOOR;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  fatce_pkg::fsm_state_t state, state_next;

  logic [fatce_pkg::LIMIT_W-1:0] cluster_limit;
  logic [AW-1:0] clr_addr;      // clearing pass pointer
  logic [16:0]   scan_addr;     // next cluster the scan reads
  logic [AW-1:0] chk_addr;      // cluster whose data is on rdata during scan
  logic          chk_valid;
  logic [15:0]   cur;           // current link during chain free
  logic [15:0]   count;         // clusters freed so far

  // RAM port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   rdata;

  // completion of the current request
  logic          fin;
  logic [15:0]   fin_value;
  logic [1:0]    fin_status;

  logic [16:0] lim;
  logic        accept;
  logic        in_range;
  logic        clr_last;
  logic        scan_hit;
  logic        scan_more;
  logic        walk_end;
  logic        walk_out;
  logic        walk_loop;

  fatce_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign lim       = ({4'b0, cluster_limit} < CAP) ? {4'b0, cluster_limit} : CAP;
  assign busy      = (state != fatce_pkg::FSM_IDLE);
  assign accept    = start && !busy;
  assign in_range  = ({1'b0, cluster} < 17'(TABLE_ENTRIES));
  assign clr_last  = (clr_addr == LAST_ADDR);
  // scan: data of chk_addr arrives on rdata in the cycle after its read was issued
  assign scan_hit  = chk_valid && (rdata == fatce_pkg::ENTRY_FREE);
  assign scan_more = (scan_addr < lim);
  // walk: a value outside 2..0xFFF7 ends the chain normally
  assign walk_end  = (cur < fatce_pkg::MIN_LINK) || (cur >= fatce_pkg::CHAIN_END_FLOOR);
  assign walk_out  = ({1'b0, cur} >= lim);
  assign walk_loop = (rdata == fatce_pkg::ENTRY_FREE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fatce_pkg::FSM_CLEAR: begin
        if (clr_last) state_next = fatce_pkg::FSM_IDLE;
      end
      fatce_pkg::FSM_IDLE: begin
        if (accept) begin
          case (fatce_pkg::mode_t'(mode))
            fatce_pkg::MODE_READ:  if (in_range) state_next = fatce_pkg::FSM_RD_WAIT;
            fatce_pkg::MODE_WRITE: state_next = fatce_pkg::FSM_IDLE;
            fatce_pkg::MODE_ALLOC: state_next = fatce_pkg::FSM_SCAN;
            default:               state_next = fatce_pkg::FSM_WALK_CHECK;
          endcase
        end
      end
      fatce_pkg::FSM_RD_WAIT: state_next = fatce_pkg::FSM_IDLE;
      fatce_pkg::FSM_SCAN: begin
        if (scan_hit || !scan_more) state_next = fatce_pkg::FSM_IDLE;
      end
      fatce_pkg::FSM_WALK_CHECK: begin
        if (walk_end || walk_out) state_next = fatce_pkg::FSM_IDLE;
        else                      state_next = fatce_pkg::FSM_WALK_DATA;
      end
      fatce_pkg::FSM_WALK_DATA: begin
        if (walk_loop) state_next = fatce_pkg::FSM_IDLE;
        else           state_next = fatce_pkg::FSM_WALK_CHECK;
      end
      default: state_next = fatce_pkg::FSM_IDLE;
    endcase
  end

  // RAM control and completion
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = fatce_pkg::ENTRY_FREE;
    mem_re     = 1'b0;
    mem_raddr  = cluster[AW-1:0];
    fin        = 1'b0;
    fin_value  = 16'd0;
    fin_status = fatce_pkg::ST_OK;
    case (state)
      fatce_pkg::FSM_CLEAR: begin
        mem_we = 1'b1;
      end
      fatce_pkg::FSM_IDLE: begin
        if (accept) begin
          case (fatce_pkg::mode_t'(mode))
            fatce_pkg::MODE_READ: begin
              if (in_range) begin
                mem_re = 1'b1;
              end else begin
                fin        = 1'b1;
                fin_status = fatce_pkg::ST_RANGE;
              end
            end
            fatce_pkg::MODE_WRITE: begin
              fin = 1'b1;
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = cluster[AW-1:0];
                mem_wdata = value;
              end else begin
                fin_status = fatce_pkg::ST_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      fatce_pkg::FSM_RD_WAIT: begin
        fin       = 1'b1;
        fin_value = rdata;
      end
      fatce_pkg::FSM_SCAN: begin
        if (scan_hit) begin
          mem_we    = 1'b1;
          mem_waddr = chk_addr;
          mem_wdata = fatce_pkg::ENTRY_EOC;
          fin       = 1'b1;
          fin_value = 16'(chk_addr);
        end else if (scan_more) begin
          mem_re    = 1'b1;
          mem_raddr = scan_addr[AW-1:0];
        end else begin
          fin        = 1'b1;
          fin_status = fatce_pkg::ST_NO_FREE;
        end
      end
      fatce_pkg::FSM_WALK_CHECK: begin
        if (walk_end) begin
          fin       = 1'b1;
          fin_value = count;
        end else if (walk_out) begin
          fin        = 1'b1;
          fin_value  = count;
          fin_status = fatce_pkg::ST_RANGE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur[AW-1:0];
        end
      end
      fatce_pkg::FSM_WALK_DATA: begin
        if (walk_loop) begin
          fin        = 1'b1;
          fin_value  = count;
          fin_status = fatce_pkg::ST_LOOP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fatce_pkg::FSM_CLEAR;
      clr_addr      <= '0;
      cluster_limit <= fatce_pkg::LIMIT_RESET;
      done          <= 1'b0;
      chk_valid     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (cfg_write) cluster_limit <= cfg_data;
      if (state == fatce_pkg::FSM_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (accept) begin
        scan_addr <= 17'(fatce_pkg::MIN_LINK);
        chk_valid <= 1'b0;
        cur       <= cluster;
        count     <= 16'd0;
      end
      if (state == fatce_pkg::FSM_SCAN && !scan_hit && scan_more) begin
        chk_addr  <= scan_addr[AW-1:0];
        chk_valid <= 1'b1;
        scan_addr <= scan_addr + 17'd1;
      end
      if (state == fatce_pkg::FSM_WALK_DATA && !walk_loop) begin
        cur   <= rdata;
        count <= count + 16'd1;
      end
    end
  end

  // result registers hold until the next completion
  always_ff @(posedge clk) begin
    if (fin) begin
      result_value <= fin_value;
      status       <= fin_status;
    end
  end

`ifndef ASSERT_OFF
  // a result only follows an accepted request or work in flight
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a request");

  // nothing is reported while the clearing pass runs
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == fatce_pkg::FSM_CLEAR) |-> !done)
    else $error("result during clearing pass");

  // a failed allocate returns cluster zero
  a_no_free_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == fatce_pkg::ST_NO_FREE) |-> (result_value == 16'd0))
    else $error("no-free status with nonzero cluster");

  // scan never checks data without a read issued the cycle before
  a_scan_read: assert property (@(posedge clk) disable iff (rst)
    (state == fatce_pkg::FSM_SCAN && chk_valid) |-> $past(mem_re))
    else $error("scan check without read");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] value;
  logic [1:0]  status;
} fat_reply_t;

// Shadow of the allocation table plus the replies it predicts, oldest first.
class alloc_table_tracker #(int ENTRIES = 4096);
  logic [15:0] table_copy [ENTRIES];
  logic [12:0] limit_reg;
  fat_reply_t  replies_due [$];
  int          errors;

  function new();
    foreach (table_copy[i]) table_copy[i] = fatce_pkg::ENTRY_FREE;
    limit_reg = fatce_pkg::LIMIT_RESET;
    errors = 0;
  endfunction

  function void set_limit(logic [12:0] lim);
    limit_reg = lim;
  endfunction

  function int usable();
    int u;
    u = limit_reg;
    if (u > ENTRIES) u = ENTRIES;
    if (u > fatce_pkg::RESERVED_FLOOR) u = fatce_pkg::RESERVED_FLOOR;
    return u;
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  // Accepted request: apply it to the shadow table, queue the reply it owes.
  function void note_request(fatce_pkg::mode_t m, logic [15:0] c, logic [15:0] v);
    fat_reply_t  r;
    int          ul;
    int          cur;
    int          freed;
    logic [15:0] link;
    r.value = fatce_pkg::ENTRY_FREE;
    r.status = fatce_pkg::ST_OK;
    ul = usable();
    case (m)
      fatce_pkg::MODE_READ: begin
        if (c >= ENTRIES) r.status = fatce_pkg::ST_RANGE;
        else r.value = table_copy[c];
      end
      fatce_pkg::MODE_WRITE: begin
        if (c >= ENTRIES) r.status = fatce_pkg::ST_RANGE;
        else table_copy[c] = v;
      end
      fatce_pkg::MODE_ALLOC: begin
        r.status = fatce_pkg::ST_NO_FREE;
        for (int i = 2; i < ul; i++) begin
          if (table_copy[i] == fatce_pkg::ENTRY_FREE) begin
            table_copy[i] = fatce_pkg::ENTRY_EOC;
            r.value = 16'(i);
            r.status = fatce_pkg::ST_OK;
            break;
          end
        end
      end
      default: begin
        cur = c;
        freed = 0;
        while (cur >= fatce_pkg::MIN_LINK && cur < fatce_pkg::CHAIN_END_FLOOR) begin
          if (cur >= ul) begin
            r.status = fatce_pkg::ST_RANGE;
            break;
          end
          link = table_copy[cur];
          if (link == fatce_pkg::ENTRY_FREE) begin
            r.status = fatce_pkg::ST_LOOP;
            break;
          end
          table_copy[cur] = fatce_pkg::ENTRY_FREE;
          freed++;
          cur = link;
        end
        r.value = 16'(freed);
      end
    endcase
    replies_due.push_back(r);
  endfunction

  function void check_reply(logic [15:0] value, logic [1:0] status);
    fat_reply_t want;
    if (replies_due.size() == 0) begin
      $display("%0t: unexpected result, value %h status %0d", $time, value, status);
      errors++;
      return;
    end
    want = replies_due.pop_front();
    if (value !== want.value) begin
      $display("%0t: result_value mismatch, expected %h, actual %h",
               $time, want.value, value);
      errors++;
    end
    if (status !== want.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d",
               $time, want.status, status);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ITEMS_TARGET  = 1800;
  // Worst case per request is a free walk over the whole table plus pacing gaps;
  // the clearing pass after reset adds to that. Taken well over.
  localparam int CYCLE_LIMIT   = 50_000_000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [15:0] cluster;
  logic [15:0] value;
  logic        done;
  logic [15:0] result_value;
  logic [1:0]  status;
  logic        cfg_write;
  logic [12:0] cfg_data;

  alloc_table_tracker #(TABLE_ENTRIES) tracker;

  int items_sent;
  int burst_left;
  int cycle_count;

  fat16_cluster_chain_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .cluster      (cluster),
    .value        (value),
    .done         (done),
    .result_value (result_value),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor: everything sampled on the rising edge. A done and a new
  // accept may land on the same edge; the done belongs to the older
  // transaction, so it is checked first.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_reply(result_value, status);
      if (start && !busy) tracker.note_request(fatce_pkg::mode_t'(mode), cluster, value);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fat16_cluster_chain_engine regression: fail");
      $finish;
    end
  end

  // One request transaction. Called at a falling edge, returns at the
  // falling edge after acceptance. Sender pacing lives here: bursts of
  // random length, random gaps between them; start stays high inside a burst.
  task automatic send_request(fatce_pkg::mode_t m, logic [15:0] c, logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      // a gap of zero now and then gives long back-to-back stretches
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    mode    <= m;
    cluster <= c;
    value   <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  // Drain all outstanding transactions, then program cluster_limit.
  task automatic program_limit(logic [12:0] lim);
    start <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= lim;
    tracker.set_limit(lim);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Cluster field: often near the usable range, also anywhere in the table,
  // around the table edge and across the full 16-bit space.
  function automatic logic [15:0] pick_cluster(int ul);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(0, ul + 3));
      4, 5:       return 16'($urandom_range(0, TABLE_ENTRIES - 1));
      6, 7:       return 16'($urandom());
      default:    return 16'($urandom_range(TABLE_ENTRIES - 6, TABLE_ENTRIES + 5));
    endcase
  endfunction

  function automatic logic [15:0] pick_value(int ul);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(0, ul + 3));
      4, 5:       return 16'($urandom_range(16'hFFF0, 16'hFFFF));
      6, 7, 8:    return 16'($urandom());
      default:    return fatce_pkg::ENTRY_FREE;
    endcase
  endfunction

  task automatic send_noise();
    int               ul;
    fatce_pkg::mode_t m;
    ul = tracker.usable();
    case ($urandom_range(0, 9))
      0, 1, 2: m = fatce_pkg::MODE_READ;
      3, 4, 5: m = fatce_pkg::MODE_WRITE;
      6, 7:    m = fatce_pkg::MODE_ALLOC;
      default: m = fatce_pkg::MODE_FREE;
    endcase
    send_request(m, pick_cluster(ul), pick_value(ul));
  endtask

  // Link a few distinct clusters into a chain, end it one of several ways
  // (clean end marker, loop back, link past the limit, link to a free or
  // reserved entry), then free it, usually from its head.
  task automatic send_chain();
    int          ul;
    int          len;
    int          cand;
    bit          dup;
    int          skip_at;
    logic [15:0] picks [6];
    logic [15:0] tail;
    ul = tracker.usable();
    len = $urandom_range(1, 6);
    if (len > ul - 2) len = ul - 2;
    for (int i = 0; i < len; i++) begin
      do begin
        cand = $urandom_range(2, ul - 1);
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (picks[j] == cand) dup = 1'b1;
      end while (dup);
      picks[i] = 16'(cand);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: tail = 16'($urandom_range(fatce_pkg::CHAIN_END_FLOOR, 16'hFFFF));
      5:             tail = picks[$urandom_range(0, len - 1)];
      6:             tail = 16'($urandom_range(ul, fatce_pkg::CHAIN_END_FLOOR - 1));
      7:             tail = 16'($urandom_range(0, 1));
      8:             tail = 16'($urandom_range(2, ul - 1));
      default:       tail = 16'($urandom_range(16'hFFF0, 16'hFFF7));
    endcase
    // occasionally leave one link stale to break the chain
    skip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i != skip_at)
        send_request(fatce_pkg::MODE_WRITE, picks[i],
                     (i == len - 1) ? tail : picks[i + 1]);
      if ($urandom_range(0, 7) == 0) send_noise();
    end
    if ($urandom_range(0, 4) == 0)
      send_request(fatce_pkg::MODE_FREE, picks[$urandom_range(0, len - 1)],
                   16'($urandom()));
    else
      send_request(fatce_pkg::MODE_FREE, picks[0], 16'($urandom()));
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if (tracker.usable() > 2 && $urandom_range(0, 2) == 0) send_chain();
      else send_noise();
    end
  endtask

  logic [12:0] phase_limits [10];
  int          per_phase;

  initial begin
    tracker = new();
    items_sent = 0;
    burst_left = 0;
    cycle_count = 0;
    rst       = 1'b1;
    start     = 1'b0;
    mode      = fatce_pkg::MODE_READ;
    cluster   = '0;
    value     = '0;
    cfg_write = 1'b0;
    cfg_data  = '0;
    phase_limits = '{13'd24, 13'd2, 13'd8191, 13'd0, 13'd300,
                     13'd3, 13'd1, 13'd4095, 13'd64, 13'd4096};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // clearing pass after reset keeps busy high
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed, at the reset limit.
    send_request(fatce_pkg::MODE_READ,  16'd0,    16'd0);
    send_request(fatce_pkg::MODE_WRITE, 16'd0,    16'hFFFF);   // cluster 0 is writable
    send_request(fatce_pkg::MODE_WRITE, 16'd1,    16'hABCD);
    send_request(fatce_pkg::MODE_READ,  16'd1,    16'd0);
    send_request(fatce_pkg::MODE_READ,  16'd4096, 16'd0);      // past the table
    send_request(fatce_pkg::MODE_WRITE, 16'hFFFF, 16'h1234);   // past the table, no effect
    send_request(fatce_pkg::MODE_READ,  16'hFFFF, 16'd0);
    send_request(fatce_pkg::MODE_WRITE, 16'd4095, 16'hFFFF);   // top entry
    send_request(fatce_pkg::MODE_READ,  16'd4095, 16'd0);
    send_request(fatce_pkg::MODE_ALLOC, 16'd0,    16'd0);
    send_request(fatce_pkg::MODE_ALLOC, 16'd0,    16'd0);
    send_request(fatce_pkg::MODE_WRITE, 16'd2,    16'd3);      // 2 -> 3 -> end
    send_request(fatce_pkg::MODE_WRITE, 16'd3,    16'hFFF8);
    send_request(fatce_pkg::MODE_FREE,  16'd2,    16'd0);
    send_request(fatce_pkg::MODE_FREE,  16'd0,    16'd0);      // starts that are not links
    send_request(fatce_pkg::MODE_FREE,  16'd1,    16'd0);
    send_request(fatce_pkg::MODE_FREE,  16'hFFF8, 16'd0);
    send_request(fatce_pkg::MODE_FREE,  16'hFFFF, 16'd0);
    send_request(fatce_pkg::MODE_WRITE, 16'd10,   16'd11);     // loop 10 <-> 11
    send_request(fatce_pkg::MODE_WRITE, 16'd11,   16'd10);
    send_request(fatce_pkg::MODE_FREE,  16'd10,   16'd0);
    send_request(fatce_pkg::MODE_WRITE, 16'd20,   16'd21);     // link into a free entry
    send_request(fatce_pkg::MODE_FREE,  16'd20,   16'd0);
    send_request(fatce_pkg::MODE_WRITE, 16'd30,   16'd4100);   // link past the limit
    send_request(fatce_pkg::MODE_FREE,  16'd30,   16'd0);

    // Random, first at the reset limit, then one phase per programmed limit.
    per_phase = (ITEMS_TARGET - items_sent) / 11;
    run_random(per_phase);
    foreach (phase_limits[p]) begin
      program_limit(phase_limits[p]);
      run_random(per_phase);
    end

    // Drain, then give a stray strobe time to show up.
    start <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (tracker.errors == 0)
      $display("fat16_cluster_chain_engine regression: pass");
    else
      $display("fat16_cluster_chain_engine regression: fail");
    $finish;
  end

endmodule
